// File: design/sbda_pkg.sv
// shared constants and controller/datapath interface types for the
// signed binary to decimal ascii converter; no dependencies
`default_nettype none
package sbda_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned CHAR_W   = 6;
   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned CNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int unsigned QUOT_W   = 29;
   localparam int unsigned PROD_W   = 2 * VALUE_W;

   // floor(n * RECIP_TEN / 2**RECIP_SHIFT) == n / 10 for every 32-bit n
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int unsigned        RECIP_SHIFT = 35;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic emit_minus;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic neg;
      logic cnt_one;
   } sts_type;

endpackage
`default_nettype wire

// File: design/sbda_datapath.sv
// datapath: magnitude register, reciprocal multiplier, digit store and char select
// depends on sbda_pkg
`default_nettype none
module sbda_datapath (
   input  wire logic                        clock,
   input  wire sbda_pkg::cmd_type           cmd,
   input  wire logic [sbda_pkg::VALUE_W-1:0] req_value,
   output sbda_pkg::sts_type                sts,
   output logic [sbda_pkg::CHAR_W-1:0]      emit_char,
   output logic                             emit_last
);

   logic [sbda_pkg::VALUE_W-1:0] mag_ff, mag_in;
   logic [sbda_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                         neg_ff, neg_in;
   logic [sbda_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]                   digit_ff [sbda_pkg::MAX_DIGITS];

   logic [sbda_pkg::QUOT_W-1:0]  quot;
   logic [sbda_pkg::VALUE_W-1:0] quot_ext;
   logic [sbda_pkg::VALUE_W-1:0] quot_x10;
   logic [sbda_pkg::VALUE_W-1:0] rem_full;
   logic [sbda_pkg::CNT_W-1:0]   rd_idx;
   logic [3:0]                   rd_digit;

   assign quot     = prod_ff[sbda_pkg::PROD_W-1:sbda_pkg::RECIP_SHIFT];
   assign quot_ext = {{(sbda_pkg::VALUE_W-sbda_pkg::QUOT_W){1'b0}}, quot};
   assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
   assign rem_full = mag_ff - quot_x10;
   assign rd_idx   = cnt_ff - sbda_pkg::CNT_W'(1);
   assign rd_digit = digit_ff[rd_idx];

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      if (cmd.load) begin
         neg_in = req_value[sbda_pkg::VALUE_W-1];
         mag_in = neg_in ? (sbda_pkg::VALUE_W'(0) - req_value) : req_value;
         cnt_in = '0;
      end
      if (cmd.mul) begin
         prod_in = sbda_pkg::PROD_W'(mag_ff) * sbda_pkg::PROD_W'(sbda_pkg::RECIP_TEN);
      end
      if (cmd.step) begin
         mag_in = quot_ext;
         cnt_in = cnt_ff + sbda_pkg::CNT_W'(1);
      end
      if (cmd.emit_digit) begin
         cnt_in = rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      if (cmd.step) begin
         digit_ff[cnt_ff] <= rem_full[3:0];
      end
   end

   assign sts.quot_zero = (quot == '0);
   assign sts.neg       = neg_ff;
   assign sts.cnt_one   = (cnt_ff == sbda_pkg::CNT_W'(1));

   assign emit_char = cmd.emit_minus ? sbda_pkg::CHAR_MINUS
                                     : sbda_pkg::CHAR_ZERO + {2'b00, rd_digit};
   assign emit_last = cmd.emit_digit && (cnt_ff == sbda_pkg::CNT_W'(1));

endmodule
`default_nettype wire

// File: design/sbda_ctrl.sv
// controller: sequences load, divide-by-ten steps and character emission
// depends on sbda_pkg
`default_nettype none
module sbda_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              slot_free,
   input  wire sbda_pkg::sts_type sts,
   output logic                   req_stall,
   output sbda_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.quot_zero) begin
               state_in = sts.neg ? ST_SIGN : ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.emit_minus = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: design/signed_binary_to_decimal_ascii.sv
// top level: controller, datapath and the result output register
// depends on sbda_pkg, sbda_ctrl, sbda_datapath
// steps: the value is taken, each decimal digit passes through the reciprocal
// multiplier and a divide step, then each character (sign, digits) enters the output register
// when it is free; a new value is taken only once the last digit has been issued
// reset clears the controller and the output valid; no store needs clearing
`default_nettype none
module signed_binary_to_decimal_ascii (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_char_code,
   output logic             rsp_last
);

   sbda_pkg::cmd_type cmd;
   sbda_pkg::sts_type sts;
   logic [sbda_pkg::CHAR_W-1:0] emit_char;
   logic                        emit_last;
   logic                        emit;
   logic                        slot_free;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sbda_pkg::CHAR_W-1:0] rsp_char_ff;
   logic                        rsp_last_ff;

   sbda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .slot_free (slot_free),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   sbda_datapath u_datapath (
      .clock     (clock),
      .cmd       (cmd),
      .req_value (req_value),
      .sts       (sts),
      .emit_char (emit_char),
      .emit_last (emit_last)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = cmd.emit_minus || cmd.emit_digit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // busy after taking a value
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("converter accepted a value without going busy");

   // the sign never ends a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_code == sbda_pkg::CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last character");

   // only the sign or a decimal digit leaves
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == sbda_pkg::CHAR_MINUS ||
                     (rsp_char_code >= sbda_pkg::CHAR_ZERO &&
                      rsp_char_code <= sbda_pkg::CHAR_ZERO + 6'd9)))
      else $error("illegal character code");

   // never overwrite a waiting character
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !emit)
      else $error("character issued while output register held");

endmodule
`default_nettype wire

// File: test/signed_binary_to_decimal_ascii_checker.sv
// checker for the signed binary to decimal ascii converter: predicts the character
// run of every accepted value and compares each result transfer against it
// depends on sbda_pkg for the character codes
`timescale 1ns / 100ps
module signed_binary_to_decimal_ascii_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_char_code,
   input  logic        rsp_last,
   output int          failures,
   output int          chars_pending
);

   typedef struct packed {
      logic [5:0] char_code;
      logic       last;
   } decimal_char_type;

   decimal_char_type expected_text[$];

   initial begin
      failures = 0;
      chars_pending = 0;
   end

   function automatic void queue_decimal_text(input logic [31:0] number);
      logic [3:0]  digit_buf[10];
      logic [31:0] magnitude;
      int          n_digits;
      decimal_char_type c;
      magnitude = number[31] ? (32'd0 - number) : number;
      n_digits = 0;
      do begin
         digit_buf[n_digits] = 4'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
         n_digits++;
      end while (magnitude != 0);
      if (number[31]) begin
         c.char_code = sbda_pkg::CHAR_MINUS;
         c.last = 1'b0;
         expected_text.push_back(c);
      end
      for (int i = n_digits - 1; i >= 0; i--) begin
         c.char_code = 6'(sbda_pkg::CHAR_ZERO + digit_buf[i]);
         c.last = (i == 0);
         expected_text.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      decimal_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            queue_decimal_text(req_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("char_code: unexpected transfer, got %0d (last %0d)",
                      rsp_char_code, rsp_last);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  $error("char_code: expected %0d, got %0d", want.char_code, rsp_char_code);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  failures++;
               end
            end
         end
      end
      chars_pending = expected_text.size();
   end

endmodule

// File: test/signed_binary_to_decimal_ascii_tb.sv
// testbench top for the signed binary to decimal ascii converter: directed and
// random values with bursty input and random output stalls
// depends on sbda_pkg, signed_binary_to_decimal_ascii and its checker module
`timescale 1ns / 100ps
module signed_binary_to_decimal_ascii_tb;

   localparam int RANDOM_VALUES = 128;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int TAIL_CYCLES   = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_char_code;
   logic        rsp_last;
   int          failures;
   int          chars_pending;
   int          cycle_count;
   int          burst_left;

   signed_binary_to_decimal_ascii uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   signed_binary_to_decimal_ascii_checker text_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .failures      (failures),
      .chars_pending (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("signed_binary_to_decimal_ascii regression: fail");
            $finish;
         end
      end
   end

   // receiver stall pattern: runs of free flow, light, heavy and random stalling
   initial begin
      int stall_mode;
      int mode_left;
      rsp_stall <= 1'b0;
      mode_left = 0;
      stall_mode = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   // entered at a falling edge, returns at the falling edge after the transfer
   task automatic send_value(input logic [31:0] number);
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            req_value <= $urandom;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= number;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (chars_pending != 0) @(negedge clock);
      burst_left = 0;
   endtask

   function automatic logic [31:0] random_value();
      longint magnitude;
      longint low_bound;
      longint high_bound;
      int     n_digits;
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2, 3: begin
            n_digits = $urandom_range(1, 10);
            low_bound = 1;
            repeat (n_digits - 1) low_bound *= 10;
            high_bound = low_bound * 10 - 1;
            if (n_digits == 1) low_bound = 0;
            if (high_bound > 64'sd2147483647) high_bound = 64'sd2147483647;
            magnitude = low_bound + longint'($urandom) % (high_bound - low_bound + 1);
            return $urandom_range(0, 1) ? 32'(-magnitude) : 32'(magnitude);
         end
         default: begin
            // neighbours of a power of ten
            magnitude = 1;
            repeat ($urandom_range(0, 9)) magnitude *= 10;
            magnitude = magnitude + $urandom_range(0, 2) - 1;
            return $urandom_range(0, 1) ? 32'(-magnitude) : 32'(magnitude);
         end
      endcase
   endfunction

   initial begin
      logic [31:0] directed_values[$];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      burst_left = 0;
      directed_values = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                          32'd99, 32'd100, -32'sd100, 32'd12345, -32'sd67890,
                          32'd999999999, 32'd1000000000, -32'sd1000000000,
                          32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
                          32'd1234567890, -32'sd1234567890, 32'hAAAA_AAAA, 32'h5555_5555};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_values[i]) send_value(directed_values[i]);
      drain_results();

      for (int i = 0; i < RANDOM_VALUES; i++) begin
         if (i == RANDOM_VALUES / 2) drain_results();
         send_value(random_value());
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0 && chars_pending == 0)
         $display("signed_binary_to_decimal_ascii regression: pass");
      else
         $display("signed_binary_to_decimal_ascii regression: fail");
      $finish;
   end

endmodule
